### hw/rtl/abcm_pkg.sv
// Shared types and constants of the credit marker.
package abcm_pkg;

  localparam int NUM_W    = 48;  // divider dividend width
  localparam int DEN_W    = 14;  // divider divisor width
  localparam int RATIO_W  = 28;  // rate ratio, Q16
  localparam int QD_W     = 42;  // queueing delay, Q16 ms
  localparam int SUBN_W   = 30;  // correction dividend after saturation check
  localparam int CREDIT_W = 19;  // credit, Q3.16

  localparam logic [CREDIT_W-1:0] Q16_ONE     = 19'd65536;
  localparam logic [CREDIT_W-1:0] CREDIT_MAX  = 19'd327680;
  localparam logic [15:0]         FACTOR_BASE = 16'd64225;
  localparam logic [51:0]         SUB_SAT     = 52'd642250000;
  // Division by 10000 is a shift by four, then a multiply by ceil(2^36 / 625)
  // and a shift by 36, exact for any dividend below 2^30.
  localparam logic [26:0]         RECIP_625   = 27'd109951163;

  typedef enum logic [7:0] {
    CFG_QDELAY_TARGET = 8'd0,
    CFG_BETA          = 8'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_RATIO  = 2'd0,
    DIV_QDELAY = 2'd1
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     win_start;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_ratio;
    logic     cap_excess;
    logic     cap_prod;
    logic     cap_sub;
    logic     cap_factor;
    logic     cap_prob;
    logic     credit_upd;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic win_busy;
    logic div_busy;
    logic qlen_zero;
    logic out_full;
  } dp_status_t;

endpackage

### hw/rtl/abcm_in_if.sv
// Request channel carrying one dequeue opportunity.
interface abcm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [15:0] queue_length;
  logic [7:0]  last_byte;
  logic [7:0]  third_last_byte;
  modport source (output valid, now_ms, queue_length, last_byte, third_last_byte,
                  input ready);
  modport sink (input valid, now_ms, queue_length, last_byte, third_last_byte,
                output ready);
endinterface

### hw/rtl/abcm_out_if.sv
// Request channel carrying one marking result.
interface abcm_out_if;
  logic       valid;
  logic       ready;
  logic       packet_valid;
  logic [7:0] new_last_byte;
  logic [7:0] new_third_last_byte;
  logic       braked;
  logic       credit_spent;
  modport source (output valid, packet_valid, new_last_byte, new_third_last_byte,
                  braked, credit_spent, input ready);
  modport sink (input valid, packet_valid, new_last_byte, new_third_last_byte,
                braked, credit_spent, output ready);
endinterface

### hw/rtl/abcm_cfg_if.sv
// Register write channel.
interface abcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/abcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module abcm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule

### hw/rtl/abcm_window.sv
// Timestamp window: trims stale entries and appends the current time.
module abcm_window #(
  parameter int DEPTH     = 256,
  parameter int WINDOW_MS = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [31:0]              now,
  output logic                     busy,
  output logic [$clog2(DEPTH):0]   count
);
  localparam int AW = $clog2(DEPTH);

  typedef enum logic [4:0] {
    W_IDLE = 5'b00001,
    W_CHK  = 5'b00010,
    W_TST  = 5'b00100,
    W_PUSH = 5'b01000,
    W_FULL = 5'b10000
  } win_state_t;

  win_state_t    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic [31:0]   oldest_r, oldest_nxt;
  logic [31:0]   now_r;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata_r;

  abcm_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(now_r), .raddr(raddr), .rdata_r(rdata_r)
  );

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    we         = 1'b0;
    waddr      = head_r + count_r[AW-1:0];
    raddr      = head_r + AW'(1);
    case (state_r)
      W_IDLE: if (start) state_nxt = W_CHK;
      W_CHK: begin
        if (count_r > (AW+1)'(1) && (now_r - oldest_r) > 32'(WINDOW_MS)) begin
          state_nxt = W_TST;
        end else begin
          state_nxt = W_PUSH;
        end
      end
      W_TST: begin
        if (now_r > rdata_r) begin
          head_nxt   = head_r + AW'(1);
          count_nxt  = count_r - (AW+1)'(1);
          oldest_nxt = rdata_r;
          state_nxt  = W_CHK;
        end else begin
          state_nxt = W_PUSH;
        end
      end
      W_PUSH: begin
        if (count_r >= (AW+1)'(DEPTH)) begin
          state_nxt = W_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + (AW+1)'(1);
          state_nxt = W_IDLE;
        end
      end
      W_FULL: begin
        // Oldest slot is reused for the new time; the next one becomes oldest.
        we         = 1'b1;
        oldest_nxt = rdata_r;
        head_nxt   = head_r + AW'(1);
        state_nxt  = W_IDLE;
      end
      default: state_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= W_IDLE;
      head_r   <= '0;
      count_r  <= (AW+1)'(1);
      oldest_r <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == W_IDLE && start) begin
      now_r <= now;
    end
  end

  assign busy  = (state_r != W_IDLE);
  assign count = count_r;
endmodule

### hw/rtl/abcm_div.sv
// Restoring divider, one quotient bit per cycle.
module abcm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [abcm_pkg::NUM_W-1:0]  num,
  input  logic [abcm_pkg::DEN_W-1:0]  den,
  output logic                        busy,
  output logic [abcm_pkg::NUM_W-1:0]  quo
);
  import abcm_pkg::*;

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(NUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;
endmodule

### hw/rtl/abcm_dp.sv
// Datapath: windows, divider, credit arithmetic, registers and result stage.
module abcm_dp #(
  parameter int WINDOW_DEPTH = 256,
  parameter int WINDOW_MS    = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  abcm_pkg::ctrl_cmd_t     cmd,
  output abcm_pkg::dp_status_t    status,
  input  logic [31:0]             in_now_ms,
  input  logic [15:0]             in_queue_length,
  input  logic [7:0]              in_last_byte,
  input  logic [7:0]              in_third_last_byte,
  input  logic                    cfg_we,
  input  logic [7:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    out_packet_valid,
  output logic [7:0]              out_new_last_byte,
  output logic [7:0]              out_new_third_last_byte,
  output logic                    out_braked,
  output logic                    out_credit_spent
);
  import abcm_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [15:0] qdelay_target_r;
  logic [9:0]  beta_r;
  logic [31:0] now_r;
  logic [15:0] qlen_r;
  logic [7:0]  lb_r, tb_r;

  logic          r_busy, o_busy;
  logic [AW:0]   r_count, o_count, rr, ro;

  logic             div_busy;
  logic [NUM_W-1:0] div_num, quo;
  logic [DEN_W-1:0] div_den;
  logic [25:0]      qlen_ms;

  logic [RATIO_W-1:0]  ratio_r;
  logic [QD_W-1:0]     excess_r, qref;
  logic [51:0]         prod;
  logic [SUBN_W-1:0]   subnum_r;
  logic                sat_r;
  logic [52:0]         sub_prod;
  logic [16:0]         sub_r;
  logic [15:0]         factor_r;
  logic [43:0]         prob_prod_r;
  logic [CREDIT_W-1:0] credit_r, prob, cr;
  logic [CREDIT_W:0]   sum;
  logic                accel, spend;

  logic       res_pv_r, res_braked_r, res_spent_r;
  logic [7:0] res_lb_r, res_tb_r;
  logic       out_valid_r, out_pv_r, out_braked_r, out_spent_r;
  logic [7:0] out_lb_r, out_tb_r;

  abcm_window #(.DEPTH(WINDOW_DEPTH), .WINDOW_MS(WINDOW_MS)) u_real (
    .clk(clk), .rst_n(rst_n), .start(cmd.win_start), .now(now_r),
    .busy(r_busy), .count(r_count)
  );

  abcm_window #(.DEPTH(WINDOW_DEPTH), .WINDOW_MS(WINDOW_MS)) u_obs (
    .clk(clk), .rst_n(rst_n), .start(cmd.win_start && qlen_r != 16'd0), .now(now_r),
    .busy(o_busy), .count(o_count)
  );

  assign rr = (r_count == (AW+1)'(1)) ? (AW+1)'(1) : r_count - (AW+1)'(1);
  assign ro = (o_count == (AW+1)'(1)) ? (AW+1)'(1) : o_count - (AW+1)'(1);
  assign qlen_ms = 26'(qlen_r) * 26'(WINDOW_MS);

  always_comb begin
    case (cmd.div_sel)
      DIV_RATIO: begin
        div_num = NUM_W'({rr, 16'b0});
        div_den = DEN_W'(ro);
      end
      DIV_QDELAY: begin
        div_num = NUM_W'({qlen_ms, 16'b0});
        div_den = DEN_W'(rr);
      end
      default: begin
        div_num = '0;
        div_den = DEN_W'(1);
      end
    endcase
  end

  abcm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(quo)
  );

  assign qref = QD_W'({qdelay_target_r, 16'b0});
  assign prod = 52'(beta_r) * 52'(excess_r);
  // Correction term divided by 10000 through the reciprocal of 625.
  assign sub_prod = 53'(subnum_r[SUBN_W-1:4]) * 53'(RECIP_625);

  // Credit update: clamp the probability to one, saturate the credit at five.
  assign prob  = (prob_prod_r[43:17] > 27'(Q16_ONE)) ? Q16_ONE
                                                      : prob_prod_r[17+CREDIT_W-1:17];
  assign sum   = {1'b0, credit_r} + {1'b0, prob};
  assign cr    = (sum > {1'b0, CREDIT_MAX}) ? CREDIT_MAX : sum[CREDIT_W-1:0];
  assign accel = (cr > Q16_ONE);
  assign spend = accel && (lb_r == tb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qdelay_target_r <= 16'd20;
      beta_r          <= 10'd100;
      credit_r        <= CREDIT_MAX;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_QDELAY_TARGET: qdelay_target_r <= cfg_data;
          CFG_BETA:          beta_r          <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (cmd.credit_upd) begin
        credit_r <= spend ? cr - Q16_ONE : cr;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r        <= in_now_ms;
      qlen_r       <= in_queue_length;
      lb_r         <= in_last_byte;
      tb_r         <= in_third_last_byte;
      res_pv_r     <= 1'b0;
      res_lb_r     <= 8'd0;
      res_tb_r     <= 8'd0;
      res_braked_r <= 1'b0;
      res_spent_r  <= 1'b0;
    end
    if (cmd.cap_ratio) begin
      ratio_r <= quo[RATIO_W-1:0];
    end
    if (cmd.cap_excess) begin
      excess_r <= (quo[QD_W-1:0] > qref) ? quo[QD_W-1:0] - qref : '0;
    end
    if (cmd.cap_prod) begin
      sat_r    <= (prod >= SUB_SAT);
      subnum_r <= prod[SUBN_W-1:0];
    end
    if (cmd.cap_sub) begin
      sub_r <= sub_prod[52:36];
    end
    if (cmd.cap_factor) begin
      factor_r <= (sat_r || sub_r >= 17'(FACTOR_BASE)) ? 16'd0
                                                        : FACTOR_BASE - sub_r[15:0];
    end
    if (cmd.cap_prob) begin
      prob_prod_r <= 44'(ratio_r) * 44'(factor_r);
    end
    if (cmd.credit_upd) begin
      res_pv_r     <= 1'b1;
      res_lb_r     <= accel ? lb_r : lb_r + 8'd1;
      res_tb_r     <= accel ? tb_r : tb_r - 8'd1;
      res_braked_r <= !accel;
      res_spent_r  <= spend;
    end
    if (cmd.out_load) begin
      out_pv_r     <= res_pv_r;
      out_lb_r     <= res_lb_r;
      out_tb_r     <= res_tb_r;
      out_braked_r <= res_braked_r;
      out_spent_r  <= res_spent_r;
    end
  end

  assign status.win_busy  = r_busy || o_busy;
  assign status.div_busy  = div_busy;
  assign status.qlen_zero = (qlen_r == 16'd0);
  assign status.out_full  = out_valid_r;

  assign out_valid               = out_valid_r;
  assign out_packet_valid        = out_pv_r;
  assign out_new_last_byte       = out_lb_r;
  assign out_new_third_last_byte = out_tb_r;
  assign out_braked              = out_braked_r;
  assign out_credit_spent        = out_spent_r;

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CREDIT_MAX) else $error("credit above maximum");
  a_brake_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_braked_r && out_spent_r)) else $error("brake and spend together");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pv_r) |-> (!out_braked_r && !out_spent_r && out_lb_r == 8'd0))
    else $error("empty result not cleared");
`endif
endmodule

### hw/rtl/abcm_ctrl.sv
// Controller state machine sequencing the datapath for one request.
module abcm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  abcm_pkg::dp_status_t  status,
  output abcm_pkg::ctrl_cmd_t   cmd
);
  import abcm_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'h0001,
    S_WSTART = 14'h0002,
    S_WWAIT  = 14'h0004,
    S_D1     = 14'h0008,
    S_W1     = 14'h0010,
    S_D2     = 14'h0020,
    S_W2     = 14'h0040,
    S_EXC    = 14'h0080,
    S_MUL    = 14'h0100,
    S_SUB    = 14'h0200,
    S_FACT   = 14'h0400,
    S_PROB   = 14'h0800,
    S_CRED   = 14'h1000,
    S_OUT    = 14'h2000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DIV_RATIO;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WSTART;
        end
      end
      S_WSTART: begin
        cmd.win_start = 1'b1;
        state_nxt     = S_WWAIT;
      end
      S_WWAIT: if (!status.win_busy) state_nxt = status.qlen_zero ? S_OUT : S_D1;
      S_D1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RATIO;
        state_nxt     = S_W1;
      end
      S_W1: if (!status.div_busy) state_nxt = S_D2;
      S_D2: begin
        cmd.cap_ratio = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_QDELAY;
        state_nxt     = S_W2;
      end
      S_W2: if (!status.div_busy) state_nxt = S_EXC;
      S_EXC: begin
        cmd.cap_excess = 1'b1;
        state_nxt      = S_MUL;
      end
      S_MUL: begin
        cmd.cap_prod = 1'b1;
        state_nxt    = S_SUB;
      end
      S_SUB: begin
        cmd.cap_sub = 1'b1;
        state_nxt   = S_FACT;
      end
      S_FACT: begin
        cmd.cap_factor = 1'b1;
        state_nxt      = S_PROB;
      end
      S_PROB: begin
        cmd.cap_prob = 1'b1;
        state_nxt    = S_CRED;
      end
      S_CRED: begin
        cmd.credit_upd = 1'b1;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

### hw/rtl/abc_credit_marker_top.sv
// Top level of the credit marker: controller, datapath and channel wiring.
//
//   channel | direction | carries
//   in_ch   | sink      | now_ms, queue_length, last_byte, third_last_byte
//   out_ch  | source    | packet_valid, new_last_byte, new_third_last_byte, braked,
//           |           | credit_spent
//   cfg_ch  | sink      | index, data (register write, always ready)
//
// One request is worked on at a time. An empty-queue request goes from acceptance to
// the result through the window update alone, which lengthens for each stale window
// entry removed, when the oldest entry is stale but the next is not and when a window
// is full; a request with a packet adds two passes through the one-bit-per-cycle
// divider and the arithmetic steps, and the divider takes the most time.
// Reset is synchronous and active low; the windows need no clearing pass since the
// oldest time is held in a register. A finished result waits in the output register
// while the next request is taken; only a second finished result stalls the block.
module abc_credit_marker_top #(
  parameter int WINDOW_DEPTH = 256,
  parameter int WINDOW_MS    = 20
) (
  input logic         clk,
  input logic         rst_n,
  abcm_in_if.sink     in_ch,
  abcm_out_if.source  out_ch,
  abcm_cfg_if.sink    cfg_ch
);
  import abcm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register writes are always taken; the user must keep the block idle (unchecked).
  assign cfg_ch.ready = 1'b1;

  abcm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .status(status), .cmd(cmd)
  );

  abcm_dp #(.WINDOW_DEPTH(WINDOW_DEPTH), .WINDOW_MS(WINDOW_MS)) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .status(status),
    .in_now_ms(in_ch.now_ms),
    .in_queue_length(in_ch.queue_length),
    .in_last_byte(in_ch.last_byte),
    .in_third_last_byte(in_ch.third_last_byte),
    .cfg_we(cfg_ch.valid),
    .cfg_index(cfg_ch.index),
    .cfg_data(cfg_ch.data),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .out_packet_valid(out_ch.packet_valid),
    .out_new_last_byte(out_ch.new_last_byte),
    .out_new_third_last_byte(out_ch.new_third_last_byte),
    .out_braked(out_ch.braked),
    .out_credit_spent(out_ch.credit_spent)
  );
endmodule

### bench/tb_top.sv
// Self-checking bench for the credit marker: random and directed dequeue opportunities.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import abcm_pkg::*;

  localparam int WIN_DEPTH = 256;
  localparam int WIN_SPAN  = 20;
  localparam int PEND_DEPTH = 16;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] queue_length;
    logic [7:0]  last_byte;
    logic [7:0]  third_last_byte;
  } opportunity_t;

  typedef struct packed {
    logic       packet_valid;
    logic [7:0] new_last_byte;
    logic [7:0] new_third_last_byte;
    logic       braked;
    logic       credit_spent;
  } marking_t;

  // Timestamp window with the same trimming rule as the block.
  class time_window;
    logic [31:0] slot [WIN_DEPTH];
    int unsigned count;
    int unsigned head;

    function void clear();
      foreach (slot[i]) slot[i] = '0;
      count = 1;
      head = 0;
    endfunction

    function logic [31:0] at(int unsigned i);
      return slot[(head + i) % WIN_DEPTH];
    endfunction

    function void drop_oldest();
      head = (head + 1) % WIN_DEPTH;
      count--;
    endfunction

    function void push(logic [31:0] now);
      logic [31:0] age;
      while (count > 1) begin
        age = now - at(0);
        if (!(age > WIN_SPAN && now > at(1))) break;
        drop_oldest();
      end
      if (count >= WIN_DEPTH) drop_oldest();
      slot[(head + count) % WIN_DEPTH] = now;
      count++;
    endfunction
  endclass

  // Scoreboard: predicts the marking of each accepted request and checks results.
  class marking_scoreboard;
    time_window      dequeues;
    time_window      departures;
    longint unsigned credit;
    logic [15:0]     target_ms;
    logic [9:0]      beta;
    marking_t        expected [PEND_DEPTH];
    int unsigned     exp_wr;
    int unsigned     exp_rd;
    int unsigned     exp_count;
    int              errors;

    function new();
      dequeues = new();
      departures = new();
      dequeues.clear();
      departures.clear();
      credit = CREDIT_MAX;
      target_ms = 16'd20;
      beta = 10'd100;
      exp_wr = 0;
      exp_rd = 0;
      exp_count = 0;
      errors = 0;
    endfunction

    function int unsigned outstanding();
      return exp_count;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] val);
      if (idx == CFG_QDELAY_TARGET) target_ms = val;
      else if (idx == CFG_BETA) beta = val[9:0];
    endfunction

    function void note_request(opportunity_t op);
      marking_t m;
      longint unsigned rr, ro, ratio, qdelay, qref, excess, sub, factor, prob;
      m = '0;
      dequeues.push(op.now_ms);
      if (op.queue_length != 0) begin
        departures.push(op.now_ms);
        rr = dequeues.count - 1;
        ro = departures.count - 1;
        if (rr == 0) rr = 1;
        if (ro == 0) ro = 1;
        ratio  = (rr << 16) / ro;
        qdelay = ((longint'(op.queue_length) * WIN_SPAN) << 16) / rr;
        qref   = longint'(target_ms) << 16;
        excess = qdelay > qref ? qdelay - qref : 0;
        sub    = (longint'(beta) * excess) / 10000;
        factor = sub >= FACTOR_BASE ? 0 : FACTOR_BASE - sub;
        prob   = (ratio * factor) >> 17;
        if (prob > Q16_ONE) prob = Q16_ONE;
        credit = credit + prob;
        if (credit > CREDIT_MAX) credit = CREDIT_MAX;
        m.packet_valid = 1'b1;
        if (credit > Q16_ONE) begin
          m.new_last_byte = op.last_byte;
          m.new_third_last_byte = op.third_last_byte;
          if (op.last_byte == op.third_last_byte) begin
            credit -= Q16_ONE;
            m.credit_spent = 1'b1;
          end
        end else begin
          m.new_last_byte = op.last_byte + 8'd1;
          m.new_third_last_byte = op.third_last_byte - 8'd1;
          m.braked = 1'b1;
        end
      end
      if (exp_count == PEND_DEPTH) begin
        $error("too many results outstanding");
        errors++;
        return;
      end
      expected[exp_wr] = m;
      exp_wr = (exp_wr + 1) % PEND_DEPTH;
      exp_count++;
    endfunction

    function void check_result(marking_t got);
      marking_t want;
      if (exp_count == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected[exp_rd];
      exp_rd = (exp_rd + 1) % PEND_DEPTH;
      exp_count--;
      if (got.packet_valid !== want.packet_valid) begin
        $error("packet_valid: expected %0d actual %0d", want.packet_valid, got.packet_valid);
        errors++;
      end
      if (got.new_last_byte !== want.new_last_byte) begin
        $error("new_last_byte: expected %0d actual %0d", want.new_last_byte,
               got.new_last_byte);
        errors++;
      end
      if (got.new_third_last_byte !== want.new_third_last_byte) begin
        $error("new_third_last_byte: expected %0d actual %0d", want.new_third_last_byte,
               got.new_third_last_byte);
        errors++;
      end
      if (got.braked !== want.braked) begin
        $error("braked: expected %0d actual %0d", want.braked, got.braked);
        errors++;
      end
      if (got.credit_spent !== want.credit_spent) begin
        $error("credit_spent: expected %0d actual %0d", want.credit_spent, got.credit_spent);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  abcm_in_if  in_ch();
  abcm_out_if out_ch();
  abcm_cfg_if cfg_ch();

  abc_credit_marker_top #(.WINDOW_DEPTH(WIN_DEPTH), .WINDOW_MS(WIN_SPAN)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  marking_scoreboard board = new();
  int unsigned send_idle_pct = 0;   // chance of a gap between requests
  int unsigned recv_idle_pct = 0;   // chance per cycle that the receiver stalls
  bit          hold_off = 1'b0;     // long receiver stall to fill the block
  logic [31:0] clock_ms = '0;       // the bench's notion of time
  longint      cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.now_ms = '0;
    in_ch.queue_length = '0;
    in_ch.last_byte = '0;
    in_ch.third_last_byte = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
  end

  // Every request and every result is judged at the rising edge.
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_ch.valid && in_ch.ready)
      board.note_request({in_ch.now_ms, in_ch.queue_length, in_ch.last_byte,
                          in_ch.third_last_byte});
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_result({out_ch.packet_valid, out_ch.new_last_byte,
                          out_ch.new_third_last_byte, out_ch.braked, out_ch.credit_spent});
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver stalls at random, and all the time while a hold-off is asked for.
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one request and keeps it up until the block takes it; valid is only
  // dropped when no further request follows straight away.
  task automatic send_request(opportunity_t op);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.now_ms <= op.now_ms;
    in_ch.queue_length <= op.queue_length;
    in_ch.last_byte <= op.last_byte;
    in_ch.third_last_byte <= op.third_last_byte;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every result is in before any register is written.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Builds a random request: time mostly steps forward by small amounts so the
  // windows fill and trim, queue lengths lean small, bytes often match.
  function automatic opportunity_t random_request();
    opportunity_t op;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) clock_ms += $urandom_range(1);
    else if (pick < 90) clock_ms += $urandom_range(8);
    else if (pick < 97) clock_ms += $urandom_range(40);
    else clock_ms += $urandom;
    op.now_ms = clock_ms;
    pick = $urandom_range(99);
    if (pick < 25) op.queue_length = 16'd0;
    else if (pick < 80) op.queue_length = 16'($urandom_range(40));
    else if (pick < 95) op.queue_length = 16'($urandom_range(2000));
    else op.queue_length = 16'($urandom);
    op.last_byte = 8'($urandom);
    op.third_last_byte = ($urandom_range(99) < 50) ? op.last_byte : 8'($urandom);
    return op;
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_request(random_request());
  endtask

  initial begin
    opportunity_t op;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests: empty queue, extreme bytes, equal bytes that accelerate,
    // bursts at one time so credit runs out and packets are braked, a wrapping
    // time jump for trimming, and the largest queue length.
    send_request({32'd0, 16'd0, 8'd0, 8'd0});
    send_request({32'd0, 16'd1, 8'd255, 8'd255});
    send_request({32'd1, 16'd65535, 8'd0, 8'd255});
    repeat (8) send_request({32'd2, 16'd65535, 8'd7, 8'd7});
    send_request({32'd2, 16'd65535, 8'd255, 8'd0});
    send_request({32'd3, 16'd5, 8'd128, 8'd128});
    send_request({32'd30, 16'd0, 8'd170, 8'd85});
    send_request({32'd60, 16'd1, 8'd85, 8'd170});
    send_request({32'hFFFF_FFF0, 16'd3, 8'd1, 8'd1});
    send_request({32'hFFFF_FFFF, 16'd32768, 8'd254, 8'd1});
    clock_ms = 32'hFFFF_FFFF;
    wait_drained();

    // Receiver slow, sender eager; with a long hold-off first so the block fills.
    send_idle_pct = 26;
    recv_idle_pct = 79;
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      random_phase(600);
    join
    wait_drained();

    write_reg(CFG_QDELAY_TARGET, 16'd1);
    write_reg(CFG_BETA, 16'd1000);
    clock_ms = 0;
    send_idle_pct = 79;
    recv_idle_pct = 26;
    random_phase(600);
    wait_drained();

    write_reg(CFG_QDELAY_TARGET, 16'd65535);
    write_reg(CFG_BETA, 16'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(300);
    wait_drained();

    // Out-of-range values are used as given, zero included.
    write_reg(CFG_QDELAY_TARGET, 16'd0);
    write_reg(CFG_BETA, 16'd0);
    random_phase(150);
    wait_drained();
    write_reg(CFG_QDELAY_TARGET, 16'($urandom_range(1, 200)));
    write_reg(CFG_BETA, 16'($urandom_range(1, 1000)));
    random_phase(150);
    wait_drained();

    if (board.errors == 0 && board.outstanding() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

### abc_credit_marker_top.f
hw/rtl/abcm_pkg.sv
hw/rtl/abcm_in_if.sv
hw/rtl/abcm_out_if.sv
hw/rtl/abcm_cfg_if.sv
hw/rtl/abcm_ram.sv
hw/rtl/abcm_window.sv
hw/rtl/abcm_div.sv
hw/rtl/abcm_dp.sv
hw/rtl/abcm_ctrl.sv
hw/rtl/abc_credit_marker_top.sv
bench/tb_top.sv
